// File: hw/rtl/tptt_pkg.sv
`default_nettype none

package tptt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_IDX_W     = 3;

    localparam logic [15:0] PORT_MASK = 16'hffff;
    localparam logic [31:0] IP_MASK   = 32'hffffffff;

    typedef enum logic [1:0] {
        ACT_LOOKUP     = 2'd0,
        ACT_CREATE     = 2'd1,
        ACT_NONCE_UPD  = 2'd2,
        ACT_ORIGIN_UPD = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_TRUSTED   = 3'd0,
        STAT_UNTRUSTED = 3'd1,
        STAT_ABSENT    = 3'd2,
        STAT_CREATED   = 3'd3,
        STAT_REPLACED  = 3'd4,
        STAT_GRANTED   = 3'd5,
        STAT_MISMATCH  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CREATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] key_upper;
        logic [63:0] key_lower;
        logic [31:0] nonce;
        logic [15:0] port;
        logic [31:0] ipv4;
        logic        trusted;
    } t_entry;

    typedef struct packed {
        t_action     action;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] nonce;
        logic [15:0] port;
        logic [31:0] ip;
    } t_req;

endpackage

`default_nettype wire

// File: hw/rtl/tptt_if.sv
`default_nettype none

interface tptt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] peer_key_high;
    logic [63:0] peer_key_low;
    logic [31:0] nonce_value;
    logic [15:0] port_value;
    logic [31:0] ip_value;

    modport source (
        output valid, action, peer_key_high, peer_key_low, nonce_value, port_value, ip_value,
        input  ready
    );
    modport sink (
        input  valid, action, peer_key_high, peer_key_low, nonce_value, port_value, ip_value,
        output ready
    );
endinterface

interface tptt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  entry_index;
    logic [15:0] mapped_port;
    logic [31:0] mapped_ip;
    logic        new_trust;

    modport source (
        output valid, status, entry_index, mapped_port, mapped_ip, new_trust,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, mapped_port, mapped_ip, new_trust,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/tptt_ram.sv
`default_nettype none

module tptt_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [ADDR_W-1:0]     i_waddr,
    input  wire logic [WIDTH-1:0]      i_wdata,
    input  wire logic [ADDR_W-1:0]     i_raddr,
    output logic      [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// File: hw/rtl/tunnel_peer_trust_table_top.sv
// create writes a free slot directly; lookup and updates scan the slots in order and
// stop at the first hit, or after the last slot when the key is absent
// throughput: one item at a time, the scan reads one table row per cycle from a single
// ram port, and a new item is taken only once the result has moved to the output register
// reset: synchronous, clears the in-use bits and the control state;
// the ram contents are left as they are and are never read for a free slot
`default_nettype none

module tunnel_peer_trust_table_top
    import tptt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tptt_req_if.sink   i_req,
    tptt_rsp_if.source o_rsp
);

    t_state               r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_in_use, n_in_use;
    logic [CNT_W-1:0]     r_issue, n_issue;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                 r_out_valid, n_out_valid;

    t_req                 r_req, n_req;
    t_status              r_res_status, n_res_status;
    logic [IDX_W-1:0]     r_res_idx, n_res_idx;
    logic [15:0]          r_res_port, n_res_port;
    logic [31:0]          r_res_ip, n_res_ip;
    logic                 r_res_new, n_res_new;

    t_status              r_out_status, n_out_status;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic [15:0]          r_out_port, n_out_port;
    logic [31:0]          r_out_ip, n_out_ip;
    logic                 r_out_new, n_out_new;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_entry               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    t_entry               ram_rd;

    logic                 scan_more;
    logic                 hit;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W+OUT_IDX_W-1:0] res_idx_ext;

    tptt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    assign scan_more   = (r_issue < CNT_W'(TABLE_ENTRIES));
    assign hit         = r_cmp_vld && r_in_use[r_cmp_idx]
                         && (ram_rd.key_upper == r_req.key_high)
                         && (ram_rd.key_lower == r_req.key_low);
    assign res_idx_ext = {{OUT_IDX_W{1'b0}}, r_res_idx};

    // first free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.mapped_port = r_out_port;
    assign o_rsp.mapped_ip   = r_out_ip;
    assign o_rsp.new_trust   = r_out_new;

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_issue      = r_issue;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_port   = r_res_port;
        n_res_ip     = r_res_ip;
        n_res_new    = r_res_new;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_port   = r_out_port;
        n_out_ip     = r_out_ip;
        n_out_new    = r_out_new;
        ram_we       = 1'b0;
        ram_waddr    = r_cmp_idx;
        ram_wdata    = '0;
        ram_raddr    = r_issue[IDX_W-1:0];

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req.action   = t_action'(i_req.action);
                    n_req.key_high = i_req.peer_key_high;
                    n_req.key_low  = i_req.peer_key_low;
                    n_req.nonce    = i_req.nonce_value;
                    n_req.port     = i_req.port_value;
                    n_req.ip       = i_req.ip_value;
                    n_res_status   = STAT_ABSENT;
                    n_res_idx      = '0;
                    n_res_port     = '0;
                    n_res_ip       = '0;
                    n_res_new      = 1'b0;
                    n_issue        = '0;
                    n_cmp_vld      = 1'b0;
                    n_state        = (t_action'(i_req.action) == ACT_CREATE) ? ST_CREATE
                                                                             : ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_issue   = scan_more ? r_issue + 1'b1 : r_issue;
                n_cmp_vld = scan_more;
                n_cmp_idx = r_issue[IDX_W-1:0];
                if (hit) begin
                    n_res_idx = r_cmp_idx;
                    n_state   = ST_DONE;
                    n_cmp_vld = 1'b0;
                    case (r_req.action)
                        ACT_LOOKUP: begin
                            if (ram_rd.trusted) begin
                                n_res_status = STAT_TRUSTED;
                                n_res_port   = ram_rd.port;
                                n_res_ip     = ram_rd.ipv4;
                            end else begin
                                n_res_status = STAT_UNTRUSTED;
                            end
                        end
                        ACT_NONCE_UPD: begin
                            if (ram_rd.nonce == r_req.nonce) begin
                                ram_we            = 1'b1;
                                ram_wdata         = ram_rd;
                                ram_wdata.port    = r_req.port;
                                ram_wdata.ipv4    = r_req.ip;
                                ram_wdata.trusted = 1'b1;
                                n_res_status      = STAT_GRANTED;
                                n_res_new         = 1'b1;
                            end else begin
                                n_res_status = STAT_MISMATCH;
                            end
                        end
                        ACT_ORIGIN_UPD: begin
                            ram_we            = 1'b1;
                            ram_wdata         = ram_rd;
                            ram_wdata.port    = r_req.port ^ PORT_MASK;
                            ram_wdata.ipv4    = r_req.ip ^ IP_MASK;
                            ram_wdata.trusted = 1'b1;
                            n_res_status      = STAT_GRANTED;
                            n_res_new         = 1'b1;
                        end
                        default: begin
                            n_res_status = STAT_ABSENT;
                            n_res_idx    = '0;
                        end
                    endcase
                end else if (r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_ENTRIES - 1))) begin
                    n_res_status = STAT_ABSENT;
                    n_res_idx    = '0;
                    n_cmp_vld    = 1'b0;
                    n_state      = ST_DONE;
                end
            end
            ST_CREATE: begin
                ram_we              = 1'b1;
                ram_waddr           = free_found ? free_idx : '0;
                ram_wdata.key_upper = r_req.key_high;
                ram_wdata.key_lower = r_req.key_low;
                ram_wdata.nonce     = r_req.nonce;
                n_in_use[ram_waddr] = 1'b1;
                n_res_idx           = ram_waddr;
                n_res_status        = free_found ? STAT_CREATED : STAT_REPLACED;
                n_state             = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = res_idx_ext[OUT_IDX_W-1:0];
                    n_out_port   = r_res_port;
                    n_out_ip     = r_res_ip;
                    n_out_new    = r_res_new;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_use    <= '0;
            r_issue     <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_cmp_idx   <= n_cmp_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_port   <= n_res_port;
        r_res_ip     <= n_res_ip;
        r_res_new    <= n_res_new;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_port   <= n_out_port;
        r_out_ip     <= n_out_ip;
        r_out_new    <= n_out_new;
    end

endmodule

`default_nettype wire

// File: hw/rtl/tptt_checker.sv
`default_nettype none

module tptt_checker
    import tptt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [2:0]  i_status,
    input wire logic [2:0]  i_entry_index,
    input wire logic [15:0] i_mapped_port,
    input wire logic [31:0] i_mapped_ip,
    input wire logic        i_new_trust
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_entry_index) && $stable(i_mapped_port) && $stable(i_mapped_ip)
            && $stable(i_new_trust))
        else $error("result changed while stalled");

    // one item in flight
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready after transfer in");

    a_new_trust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_new_trust == (i_status == STAT_GRANTED)))
        else $error("new_trust does not match status");

    a_mapping_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != STAT_TRUSTED) |-> (i_mapped_port == '0)
            && (i_mapped_ip == '0))
        else $error("mapping shown without trusted hit");

    a_absent_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == STAT_ABSENT) |-> (i_entry_index == '0))
        else $error("absent result with nonzero index");

endmodule

bind tunnel_peer_trust_table_top tptt_checker u_tptt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_entry_index (o_rsp.entry_index),
    .i_mapped_port (o_rsp.mapped_port),
    .i_mapped_ip   (o_rsp.mapped_ip),
    .i_new_trust   (o_rsp.new_trust)
);

`default_nettype wire

// File: tb/sv/tb_tunnel_peer_trust_table_top.sv
`timescale 1ns / 100ps

module tb_tunnel_peer_trust_table_top;
    import tptt_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [OUT_IDX_W-1:0]   entry_index;
        logic [15:0]            mapped_port;
        logic [31:0]            mapped_ip;
        logic                   new_trust;
    } t_trust_result;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_KEYS    = 12;
    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 250;

    localparam logic [63:0] KEY_ZERO = 64'h0;
    localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] KEY_A_HI = 64'h2001_0db8_0000_0001;
    localparam logic [63:0] KEY_A_LO = 64'h8000_f227_5a3c_0012;

    logic i_clk;
    logic i_rst_n;

    tptt_req_if req_if ();
    tptt_rsp_if rsp_if ();

    tunnel_peer_trust_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_req          pending_items[$];
    t_trust_result expected_results[$];

    logic          peer_in_use  [TABLE_ENTRIES];
    logic          peer_trusted [TABLE_ENTRIES];
    logic [63:0]   peer_key_hi  [TABLE_ENTRIES];
    logic [63:0]   peer_key_lo  [TABLE_ENTRIES];
    logic [31:0]   peer_nonce   [TABLE_ENTRIES];
    logic [15:0]   peer_port    [TABLE_ENTRIES];
    logic [31:0]   peer_ip      [TABLE_ENTRIES];

    logic [63:0]   pool_hi    [POOL_KEYS];
    logic [63:0]   pool_lo    [POOL_KEYS];
    logic [31:0]   pool_nonce [POOL_KEYS];

    int            cycle_count = 0;
    int            items_in = 0;
    int            results_out = 0;
    int            mismatch_count = 0;
    int            status_seen [8];
    logic          req_fire = 1'b0;
    logic          hold_off;
    logic          no_idle;
    t_req          next_req;

    assign no_idle = (items_in >= 700) && (items_in < 1000);

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on response %0d: %s got %0h expected %0h",
                 $time, results_out, field, got, want);
    endtask

    task automatic predict_peer_table(input t_req r);
        t_trust_result res;
        int            hit;
        int            slot;
        int            i;
        res = '0;
        res.status = STAT_ABSENT;
        hit = -1;
        slot = 0;
        if (r.action == ACT_CREATE) begin
            slot = -1;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (!peer_in_use[i] && slot < 0) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                slot = 0;
                res.status = STAT_REPLACED;
            end else begin
                res.status = STAT_CREATED;
            end
            peer_in_use[slot]  = 1'b1;
            peer_trusted[slot] = 1'b0;
            peer_key_hi[slot]  = r.key_high;
            peer_key_lo[slot]  = r.key_low;
            peer_nonce[slot]   = r.nonce;
            peer_port[slot]    = '0;
            peer_ip[slot]      = '0;
        end else begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit < 0 && peer_in_use[i] && peer_key_hi[i] == r.key_high
                        && peer_key_lo[i] == r.key_low) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                slot = hit;
                case (r.action)
                    ACT_LOOKUP: begin
                        if (peer_trusted[hit]) begin
                            res.status      = STAT_TRUSTED;
                            res.mapped_port = peer_port[hit];
                            res.mapped_ip   = peer_ip[hit];
                        end else begin
                            res.status = STAT_UNTRUSTED;
                        end
                    end
                    ACT_NONCE_UPD: begin
                        if (peer_nonce[hit] == r.nonce) begin
                            peer_trusted[hit] = 1'b1;
                            peer_port[hit]    = r.port;
                            peer_ip[hit]      = r.ip;
                            res.status        = STAT_GRANTED;
                            res.new_trust     = 1'b1;
                        end else begin
                            res.status = STAT_MISMATCH;
                        end
                    end
                    default: begin
                        peer_trusted[hit] = 1'b1;
                        peer_port[hit]    = r.port ^ PORT_MASK;
                        peer_ip[hit]      = r.ip ^ IP_MASK;
                        res.status        = STAT_GRANTED;
                        res.new_trust     = 1'b1;
                    end
                endcase
            end
        end
        res.entry_index = slot[OUT_IDX_W-1:0];
        expected_results.push_back(res);
    endtask

    task automatic check_trust_result(input t_trust_result got);
        t_trust_result want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("[%0t] response %0d arrived with nothing expected", $time, results_out);
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.entry_index !== want.entry_index)
                report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
            if (got.mapped_port !== want.mapped_port)
                report_mismatch("mapped_port", 64'(got.mapped_port), 64'(want.mapped_port));
            if (got.mapped_ip !== want.mapped_ip)
                report_mismatch("mapped_ip", 64'(got.mapped_ip), 64'(want.mapped_ip));
            if (got.new_trust !== want.new_trust)
                report_mismatch("new_trust", 64'(got.new_trust), 64'(want.new_trust));
        end
        if (!$isunknown(got.status))
            status_seen[got.status]++;
        results_out++;
    endtask

    task automatic add_item(input t_action act, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [31:0] nonce, input logic [15:0] port,
                            input logic [31:0] ip);
        t_req r;
        r.action   = act;
        r.key_high = hi;
        r.key_low  = lo;
        r.nonce    = nonce;
        r.port     = port;
        r.ip       = ip;
        pending_items.push_back(r);
    endtask

    task automatic add_random_item();
        t_req r;
        int   k;
        int   pick;
        k          = $urandom_range(0, POOL_KEYS - 1);
        r.action   = t_action'($urandom_range(0, 3));
        r.key_high = {$urandom, $urandom};
        r.key_low  = {$urandom, $urandom};
        r.nonce    = $urandom;
        r.port     = 16'($urandom_range(0, 65535));
        r.ip       = $urandom;
        if ($urandom_range(0, 99) >= 20) begin
            r.key_high = pool_hi[k];
            r.key_low  = pool_lo[k];
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.action = ACT_LOOKUP;
            else if (pick < 50)
                r.action = ACT_CREATE;
            else if (pick < 80)
                r.action = ACT_NONCE_UPD;
            else
                r.action = ACT_ORIGIN_UPD;
            if ((r.action == ACT_CREATE || r.action == ACT_NONCE_UPD)
                    && $urandom_range(0, 3) != 0)
                r.nonce = pool_nonce[k];
            if ($urandom_range(0, 15) == 0)
                r.port = ($urandom_range(0, 1) != 0) ? PORT_MASK : '0;
            if ($urandom_range(0, 15) == 0)
                r.ip = ($urandom_range(0, 1) != 0) ? IP_MASK : '0;
        end
        pending_items.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // input transfer: predict; output transfer: check
    always @(posedge i_clk) begin : monitor
        t_req          taken;
        t_trust_result got;
        cycle_count <= cycle_count + 1;
        req_fire    <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            taken.action   = t_action'(req_if.action);
            taken.key_high = req_if.peer_key_high;
            taken.key_low  = req_if.peer_key_low;
            taken.nonce    = req_if.nonce_value;
            taken.port     = req_if.port_value;
            taken.ip       = req_if.ip_value;
            predict_peer_table(taken);
            items_in <= items_in + 1;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status      = t_status'(rsp_if.status);
            got.entry_index = rsp_if.entry_index;
            got.mapped_port = rsp_if.mapped_port;
            got.mapped_ip   = rsp_if.mapped_ip;
            got.new_trust   = rsp_if.new_trust;
            check_trust_result(got);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_req = pending_items.pop_front();
                req_if.action        <= next_req.action;
                req_if.peer_key_high <= next_req.key_high;
                req_if.peer_key_low  <= next_req.key_low;
                req_if.nonce_value   <= next_req.nonce;
                req_if.port_value    <= next_req.port;
                req_if.ip_value      <= next_req.ip;
                req_if.valid         <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // receiver holds off while the sender keeps offering
    initial begin
        int round;
        int held;
        hold_off = 1'b0;
        for (round = 0; round < 2; round++) begin
            while (items_in < 300 + round * 1000)
                @(posedge i_clk);
            hold_off = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
                @(posedge i_clk);
            hold_off = 1'b0;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int i;
        int k;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = '0;
        req_if.peer_key_high = '0;
        req_if.peer_key_low  = '0;
        req_if.nonce_value   = '0;
        req_if.port_value    = '0;
        req_if.ip_value      = '0;
        rsp_if.ready         = 1'b0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            peer_in_use[i]  = 1'b0;
            peer_trusted[i] = 1'b0;
            peer_key_hi[i]  = '0;
            peer_key_lo[i]  = '0;
            peer_nonce[i]   = '0;
            peer_port[i]    = '0;
            peer_ip[i]      = '0;
        end
        // pairs share one half of the key to exercise partial matches
        for (k = 0; k < POOL_KEYS; k++) begin
            pool_hi[k]    = {$urandom, $urandom};
            pool_lo[k]    = (k >= 8) ? pool_lo[k - 8] : {$urandom, $urandom};
            pool_nonce[k] = $urandom;
        end
        pool_hi[1] = pool_hi[0];
        pool_hi[3] = pool_hi[2];

        // free slots never match, the all-zero key included
        add_item(ACT_LOOKUP,     KEY_ZERO, KEY_ZERO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_NONCE_UPD,  KEY_ZERO, KEY_ZERO, 32'h0, 16'h1234, 32'h0a00_0001);
        add_item(ACT_ORIGIN_UPD, KEY_ZERO, KEY_ZERO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_CREATE,     KEY_ZERO, KEY_ZERO, 32'h0, 16'hffff, 32'hffff_ffff);
        add_item(ACT_LOOKUP,     KEY_ZERO, KEY_ZERO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_CREATE,     KEY_ONES, KEY_ONES, 32'hffff_ffff, 16'h0, 32'h0);
        // duplicate key, lower slot wins
        add_item(ACT_CREATE,     KEY_A_HI, KEY_A_LO, 32'h1357_9bdf, 16'h0, 32'h0);
        add_item(ACT_CREATE,     KEY_A_HI, KEY_A_LO, 32'h2468_ace0, 16'h0, 32'h0);
        add_item(ACT_NONCE_UPD,  KEY_A_HI, KEY_A_LO, 32'h2468_ace0, 16'h0101, 32'h0101_0101);
        add_item(ACT_NONCE_UPD,  KEY_A_HI, KEY_A_LO, 32'h1357_9bdf, 16'hffff, 32'hffff_ffff);
        add_item(ACT_LOOKUP,     KEY_A_HI, KEY_A_LO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_NONCE_UPD,  KEY_A_HI, KEY_A_LO, 32'h1357_9bdf, 16'h0, 32'h0);
        add_item(ACT_LOOKUP,     KEY_A_HI, KEY_A_LO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_ORIGIN_UPD, KEY_ONES, KEY_ONES, 32'h0, 16'h0, 32'h0);
        add_item(ACT_LOOKUP,     KEY_ONES, KEY_ONES, 32'h0, 16'h0, 32'h0);
        add_item(ACT_ORIGIN_UPD, KEY_ONES, KEY_ONES, 32'h0, 16'hffff, 32'hffff_ffff);
        add_item(ACT_LOOKUP,     KEY_ONES, KEY_ONES, 32'h0, 16'h0, 32'h0);
        for (k = 0; k < 4; k++)
            add_item(ACT_CREATE, pool_hi[k], pool_lo[k], pool_nonce[k], 16'h0, 32'h0);
        // full table, slot 0 is overwritten
        add_item(ACT_CREATE,     pool_hi[4], pool_lo[4], pool_nonce[4], 16'h0, 32'h0);
        add_item(ACT_LOOKUP,     KEY_ZERO, KEY_ZERO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_LOOKUP,     pool_hi[4], pool_lo[4], 32'h0, 16'h0, 32'h0);
        add_item(ACT_LOOKUP,     KEY_A_HI, ~KEY_A_LO, 32'h0, 16'h0, 32'h0);
        add_item(ACT_ORIGIN_UPD, KEY_A_HI, KEY_A_LO, 32'h0, 16'h5aa5, 32'hc0a8_0001);
        add_item(ACT_LOOKUP,     KEY_A_HI, KEY_A_LO, 32'h0, 16'h0, 32'h0);
        for (i = 0; i < RANDOM_ITEMS; i++)
            add_random_item();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d requests in, %0d responses checked, %0d mismatches",
                 items_in, results_out, mismatch_count);
        $display("outcomes: trusted %0d untrusted %0d absent %0d created %0d replaced %0d granted %0d nonce-miss %0d",
                 status_seen[STAT_TRUSTED], status_seen[STAT_UNTRUSTED],
                 status_seen[STAT_ABSENT], status_seen[STAT_CREATED],
                 status_seen[STAT_REPLACED], status_seen[STAT_GRANTED],
                 status_seen[STAT_MISMATCH]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
